FILE: hw/rtl/stdr_pkg.sv
// Shared types, widths and stencil tables for the stencil derivative ratio block.
// Used by stdr_dp, stdr_ctrl and stencil_derivative_ratio_top; depends on nothing.
package stdr_pkg;

    // Field widths of the channels
    localparam int SAMPLE_BITS  = 24;
    localparam int INDEX_BITS   = 20;
    localparam int DERIV_BITS   = 40;
    localparam int RATIO_BITS   = 48;
    localparam int SPACING_BITS = 16;

    localparam logic [SPACING_BITS-1:0] SPACING_RESET = 16'd256;

    // Window and stencil
    localparam int WINDOW_TAPS = 5;
    localparam int TAP_BITS    = 3;
    localparam int WEIGHT_BITS = 7;
    localparam int SUM_BITS    = SAMPLE_BITS + 8;
    localparam int PROD_BITS   = SUM_BITS + SPACING_BITS + 1;

    // Scaling by 1/3072 = (1/1024) * (1/3): shift, then a digit-serial divide by three
    localparam int SCALE_SHIFT = 10;
    localparam int MAG_BITS    = PROD_BITS - SCALE_SHIFT;
    localparam int DIV3_DIGIT  = 4;
    localparam int DIV3_STEPS  = (MAG_BITS + DIV3_DIGIT - 1) / DIV3_DIGIT;
    localparam int DIV3_BITS   = DIV3_STEPS * DIV3_DIGIT;
    localparam int STEP_BITS   = $clog2(DIV3_STEPS);

    // Ratio division
    localparam int NUM_BITS  = 2 * SAMPLE_BITS;
    localparam int DEN_BITS  = DERIV_BITS;
    localparam int DCMP_BITS = ((DIV3_BITS > DERIV_BITS) ? DIV3_BITS : DERIV_BITS) + 1;
    localparam int RCMP_BITS = ((NUM_BITS > RATIO_BITS) ? NUM_BITS : RATIO_BITS) + 1;

    typedef enum logic [1:0] {
        STENCIL_FIRST   = 2'd0,
        STENCIL_SECOND  = 2'd1,
        STENCIL_CENTRAL = 2'd2
    } t_stencil;

    typedef enum logic [1:0] {
        RUN_NONE  = 2'd0,
        RUN_THREE = 2'd1,
        RUN_ONE   = 2'd2
    } t_run;

    typedef struct packed {
        logic                          series_start;
        logic signed [SAMPLE_BITS-1:0] sample_value;
    } t_in;

    typedef struct packed {
        logic        [INDEX_BITS-1:0]  sample_index;
        logic signed [SAMPLE_BITS-1:0] reported_sample;
        logic signed [DERIV_BITS-1:0]  derivative;
        logic signed [RATIO_BITS-1:0]  ratio;
        logic                          zero_derivative;
        logic                          last_of_run;
    } t_out;

    typedef struct packed {
        logic                load;
        logic                mac;
        logic [TAP_BITS-1:0] tap;
        t_stencil            kind;
        logic                scale;
        logic                absval;
        logic                div3;
        logic                deriv;
        logic                div_start;
        logic                push;
    } t_dp_cmd;

    typedef struct packed {
        t_run run;
        logic deriv_zero;
        logic div_busy;
        logic out_free;
    } t_dp_stat;

    function automatic logic signed [WEIGHT_BITS-1:0] stencil_weight(
        input t_stencil kind, input logic [TAP_BITS-1:0] tap);
        logic signed [WEIGHT_BITS-1:0] w;
        w = '0;
        case (kind)
            STENCIL_FIRST: begin
                case (tap)
                    3'd0:    w = -7'sd25;
                    3'd1:    w = 7'sd48;
                    3'd2:    w = -7'sd36;
                    3'd3:    w = 7'sd16;
                    3'd4:    w = -7'sd3;
                    default: w = '0;
                endcase
            end
            STENCIL_SECOND: begin
                case (tap)
                    3'd0:    w = -7'sd3;
                    3'd1:    w = -7'sd10;
                    3'd2:    w = 7'sd18;
                    3'd3:    w = -7'sd6;
                    3'd4:    w = 7'sd1;
                    default: w = '0;
                endcase
            end
            default: begin
                case (tap)
                    3'd0:    w = 7'sd1;
                    3'd1:    w = -7'sd8;
                    3'd3:    w = 7'sd8;
                    3'd4:    w = -7'sd1;
                    default: w = '0;
                endcase
            end
        endcase
        return w;
    endfunction

    // Window position of the sample that a stencil reports
    function automatic logic [TAP_BITS-1:0] center_tap(input t_stencil kind);
        logic [TAP_BITS-1:0] t;
        case (kind)
            STENCIL_FIRST:  t = TAP_BITS'(0);
            STENCIL_SECOND: t = TAP_BITS'(1);
            default:        t = TAP_BITS'(2);
        endcase
        return t;
    endfunction

endpackage

FILE: hw/rtl/stdr_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, unsigned operands.
// Standalone; instantiated by stdr_dp.
module stdr_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quot;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   trial;
    logic             qbit;
    logic [DEN_W-1:0] n_rem;

    always_comb begin
        shifted = {r_rem, r_quot[NUM_W-1]};
        trial   = shifted - {1'b0, r_den};
        qbit    = ~trial[DEN_W];
        n_rem   = qbit ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_quot <= {r_quot[NUM_W-2:0], qbit};
            r_rem  <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

endmodule

FILE: hw/rtl/stdr_dp.sv
// Datapath: sample window, stencil accumulate, scaling, ratio division, output register.
// Depends on stdr_pkg and stdr_div; driven by stdr_ctrl commands.
module stdr_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [stdr_pkg::SPACING_BITS-1:0]  i_cfg_wdata,
    input  stdr_pkg::t_in                      i_in,
    input  stdr_pkg::t_dp_cmd                  i_cmd,
    output stdr_pkg::t_dp_stat                 o_stat,
    output stdr_pkg::t_out                     o_out,
    output logic                               o_out_valid,
    input  logic                               i_out_ready
);

    localparam int SB   = stdr_pkg::SAMPLE_BITS;
    localparam int IB   = stdr_pkg::INDEX_BITS;
    localparam int TB   = stdr_pkg::TAP_BITS;
    localparam int DB   = stdr_pkg::DERIV_BITS;
    localparam int RB   = stdr_pkg::RATIO_BITS;
    localparam int D3B  = stdr_pkg::DIV3_BITS;
    localparam int D3D  = stdr_pkg::DIV3_DIGIT;
    localparam int PB   = stdr_pkg::PROD_BITS;
    localparam int SUMB = stdr_pkg::SUM_BITS;
    localparam int MB   = stdr_pkg::MAG_BITS;
    localparam int DCB  = stdr_pkg::DCMP_BITS;
    localparam int RCB  = stdr_pkg::RCMP_BITS;
    localparam int NB   = stdr_pkg::NUM_BITS;

    localparam logic [TB-1:0] LAST_TAP  = TB'(stdr_pkg::WINDOW_TAPS - 1);
    localparam logic [TB-1:0] SEEN_FULL = TB'(stdr_pkg::WINDOW_TAPS);
    localparam logic [IB-1:0] FIRST_INDEX   = IB'(0);
    localparam logic [IB-1:0] SECOND_INDEX  = IB'(1);
    localparam logic [IB-1:0] CENTRAL_INDEX = IB'(2);
    localparam logic [2:0]    DIV3_DIVISOR  = 3'd3;

    localparam logic [DCB-1:0] DNEG_LIM = DCB'(1) << (DB - 1);
    localparam logic [DCB-1:0] DPOS_LIM = DNEG_LIM - DCB'(1);
    localparam logic [RCB-1:0] RNEG_LIM = RCB'(1) << (RB - 1);
    localparam logic [RCB-1:0] RPOS_LIM = RNEG_LIM - RCB'(1);

    // Control state
    logic [stdr_pkg::SPACING_BITS-1:0] r_inv;
    logic [TB-1:0]                     r_seen;
    logic [IB-1:0]                     r_next_index;
    logic                              r_out_valid;

    // Payload
    logic signed [SB-1:0]   r_win [0:stdr_pkg::WINDOW_TAPS-1];
    logic signed [SUMB-1:0] r_acc;
    logic signed [SB-1:0]   r_center;
    logic [IB-1:0]          r_index;
    stdr_pkg::t_stencil     r_kind;
    logic signed [PB-1:0]   r_prod;
    logic                   r_neg;
    logic [D3B-1:0]         r_dsh;
    logic [1:0]             r_rem3;
    logic [DB-1:0]          r_deriv;
    logic [DB-1:0]          r_den;
    logic                   r_zero;
    logic [NB-1:0]          r_num;
    stdr_pkg::t_out         r_out;

    logic [TB-1:0]          eff_seen;
    logic signed [SB-1:0]   win_tap;
    logic signed [SUMB-1:0] mac_term;
    logic signed [PB-1:0]   prod_val;
    logic [PB-1:0]          prod_mag;
    logic [D3B-1:0]         dsh_load;
    logic [1:0]             d3_rem;
    logic [2:0]             d3_t;
    logic [D3D-1:0]         d3_q;
    logic [DCB-1:0]         dq_ext;
    logic [DB-1:0]          den_mag;
    logic [DB-1:0]          deriv_val;
    logic signed [NB-1:0]   square;
    logic                   div_busy;
    logic [NB-1:0]          div_quot;
    logic [RCB-1:0]         rq_ext;
    logic [RB-1:0]          ratio_val;

    // A series start empties the window, so this beat counts as its first sample
    assign eff_seen = i_in.series_start ? '0 : r_seen;

    always_comb begin
        o_stat.run = stdr_pkg::RUN_NONE;
        if (eff_seen == LAST_TAP) begin
            o_stat.run = stdr_pkg::RUN_THREE;
        end else if (eff_seen == SEEN_FULL) begin
            o_stat.run = stdr_pkg::RUN_ONE;
        end
        o_stat.deriv_zero = r_zero;
        o_stat.div_busy   = div_busy;
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    assign win_tap  = r_win[i_cmd.tap];
    assign mac_term = SUMB'(stdr_pkg::stencil_weight(i_cmd.kind, i_cmd.tap)) * SUMB'(win_tap);
    assign prod_val = PB'(r_acc) * PB'($signed({1'b0, r_inv}));
    assign prod_mag = r_prod[PB-1] ? PB'(-r_prod) : PB'(r_prod);

    always_comb begin
        dsh_load = '0;
        dsh_load[MB-1:0] = prod_mag[PB-1:stdr_pkg::SCALE_SHIFT];
    end

    // Divide by three, one digit of quotient bits per cycle, MSB first
    always_comb begin
        d3_rem = r_rem3;
        d3_q   = '0;
        d3_t   = '0;
        for (int i = 0; i < D3D; i++) begin
            d3_t = {d3_rem, r_dsh[D3B-1-i]};
            if (d3_t >= DIV3_DIVISOR) begin
                d3_rem         = 2'(d3_t - DIV3_DIVISOR);
                d3_q[D3D-1-i]  = 1'b1;
            end else begin
                d3_rem = d3_t[1:0];
            end
        end
    end

    // Sign and saturate the derivative
    always_comb begin
        dq_ext = DCB'(r_dsh);
        if (r_neg) begin
            den_mag   = (dq_ext > DNEG_LIM) ? DNEG_LIM[DB-1:0] : dq_ext[DB-1:0];
            deriv_val = '0 - den_mag;
        end else begin
            den_mag   = (dq_ext > DPOS_LIM) ? DPOS_LIM[DB-1:0] : dq_ext[DB-1:0];
            deriv_val = den_mag;
        end
    end

    assign square = NB'(r_center) * NB'(r_center);

    stdr_div #(
        .NUM_W (NB),
        .DEN_W (stdr_pkg::DEN_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    // Sign and saturate the ratio
    always_comb begin
        rq_ext = RCB'(div_quot);
        if (r_zero) begin
            ratio_val = '0;
        end else if (!r_neg) begin
            ratio_val = (rq_ext > RPOS_LIM) ? RPOS_LIM[RB-1:0] : rq_ext[RB-1:0];
        end else if (rq_ext > RNEG_LIM) begin
            ratio_val = RNEG_LIM[RB-1:0];
        end else begin
            ratio_val = '0 - rq_ext[RB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv        <= stdr_pkg::SPACING_RESET;
            r_seen       <= '0;
            r_next_index <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_inv <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_seen <= (eff_seen < SEEN_FULL) ? eff_seen + 1'b1 : eff_seen;
                if (i_in.series_start) begin
                    r_next_index <= '0;
                end else if (eff_seen == LAST_TAP) begin
                    r_next_index <= CENTRAL_INDEX;
                end
            end
            if (i_cmd.mac && i_cmd.tap == '0 && i_cmd.kind == stdr_pkg::STENCIL_CENTRAL
                && r_next_index != '1) begin
                r_next_index <= r_next_index + 1'b1;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (i_in.series_start) begin
                for (int k = 0; k < stdr_pkg::WINDOW_TAPS; k++) begin
                    r_win[k] <= '0;
                end
            end
            if (eff_seen < SEEN_FULL) begin
                r_win[eff_seen] <= i_in.sample_value;
            end else begin
                for (int k = 0; k < stdr_pkg::WINDOW_TAPS - 1; k++) begin
                    r_win[k] <= r_win[k+1];
                end
                r_win[LAST_TAP] <= i_in.sample_value;
            end
        end
        if (i_cmd.mac) begin
            r_acc <= ((i_cmd.tap == '0) ? '0 : r_acc) + mac_term;
            if (i_cmd.tap == stdr_pkg::center_tap(i_cmd.kind)) begin
                r_center <= win_tap;
            end
            if (i_cmd.tap == '0) begin
                r_kind <= i_cmd.kind;
                case (i_cmd.kind)
                    stdr_pkg::STENCIL_FIRST:  r_index <= FIRST_INDEX;
                    stdr_pkg::STENCIL_SECOND: r_index <= SECOND_INDEX;
                    default:                  r_index <= r_next_index;
                endcase
            end
        end
        if (i_cmd.scale) begin
            r_prod <= prod_val;
        end
        if (i_cmd.absval) begin
            r_neg  <= r_prod[PB-1];
            r_dsh  <= dsh_load;
            r_rem3 <= '0;
        end
        if (i_cmd.div3) begin
            r_dsh  <= {r_dsh[D3B-D3D-1:0], d3_q};
            r_rem3 <= d3_rem;
        end
        if (i_cmd.deriv) begin
            r_deriv <= deriv_val;
            r_den   <= den_mag;
            r_zero  <= (den_mag == '0);
            r_num   <= NB'(square);
        end
        if (i_cmd.push) begin
            r_out.sample_index    <= r_index;
            r_out.reported_sample <= r_center;
            r_out.derivative      <= $signed(r_deriv);
            r_out.ratio           <= $signed(ratio_val);
            r_out.zero_derivative <= r_zero;
            r_out.last_of_run     <= (r_kind == stdr_pkg::STENCIL_CENTRAL);
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.zero_derivative == (o_out.derivative == '0)))
        else $error("zero flag disagrees with derivative");

    a_zero_ratio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.zero_derivative) |-> (o_out.ratio == '0))
        else $error("ratio not cleared on zero derivative");

    a_edge_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.last_of_run) |-> (o_out.sample_index < CENTRAL_INDEX))
        else $error("edge stencil result with wrong index");

endmodule

FILE: hw/rtl/stdr_ctrl.sv
// Controller state machine: sequences window load, accumulate, scaling and division.
// Depends on stdr_pkg; drives stdr_dp through command and status structs.
module stdr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  stdr_pkg::t_dp_stat i_stat,
    output stdr_pkg::t_dp_cmd  o_cmd
);

    localparam int TB = stdr_pkg::TAP_BITS;
    localparam int SB = stdr_pkg::STEP_BITS;
    localparam logic [TB-1:0] LAST_TAP  = TB'(stdr_pkg::WINDOW_TAPS - 1);
    localparam logic [SB-1:0] LAST_STEP = SB'(stdr_pkg::DIV3_STEPS - 1);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_MAC      = 9'b000000010,
        S_SCALE    = 9'b000000100,
        S_ABS      = 9'b000001000,
        S_DIV3     = 9'b000010000,
        S_DERIV    = 9'b000100000,
        S_DIVSTART = 9'b001000000,
        S_DIVIDE   = 9'b010000000,
        S_PUSH     = 9'b100000000
    } t_state;

    t_state             r_state, n_state;
    logic [TB-1:0]      r_tap, n_tap;
    logic [SB-1:0]      r_step, n_step;
    stdr_pkg::t_stencil r_kind, n_kind;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_tap       = r_tap;
        n_step      = r_step;
        n_kind      = r_kind;
        o_cmd       = '0;
        o_cmd.tap   = r_tap;
        o_cmd.kind  = r_kind;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_tap      = '0;
                    case (i_stat.run)
                        stdr_pkg::RUN_THREE: begin
                            n_kind  = stdr_pkg::STENCIL_FIRST;
                            n_state = S_MAC;
                        end
                        stdr_pkg::RUN_ONE: begin
                            n_kind  = stdr_pkg::STENCIL_CENTRAL;
                            n_state = S_MAC;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_MAC: begin
                o_cmd.mac = 1'b1;
                if (r_tap == LAST_TAP) begin
                    n_state = S_SCALE;
                end else begin
                    n_tap = r_tap + 1'b1;
                end
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_ABS;
            end
            S_ABS: begin
                o_cmd.absval = 1'b1;
                n_step       = '0;
                n_state      = S_DIV3;
            end
            S_DIV3: begin
                o_cmd.div3 = 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = S_DERIV;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DERIV: begin
                o_cmd.deriv = 1'b1;
                n_state     = S_DIVSTART;
            end
            S_DIVSTART: begin
                if (i_stat.deriv_zero) begin
                    n_state = S_PUSH;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                if (!i_stat.div_busy) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_tap      = '0;
                    case (r_kind)
                        stdr_pkg::STENCIL_FIRST: begin
                            n_kind  = stdr_pkg::STENCIL_SECOND;
                            n_state = S_MAC;
                        end
                        stdr_pkg::STENCIL_SECOND: begin
                            n_kind  = stdr_pkg::STENCIL_CENTRAL;
                            n_state = S_MAC;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= '0;
            r_step  <= '0;
            r_kind  <= stdr_pkg::STENCIL_CENTRAL;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
            r_step  <= n_step;
            r_kind  <= n_kind;
        end
    end

    a_accept_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> !i_stat.div_busy)
        else $error("beat accepted while divider busy");

    a_load_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_IDLE || (r_state == S_MAC && r_tap == '0)))
        else $error("load not followed by idle or first tap");

endmodule

FILE: hw/rtl/stencil_derivative_ratio_top.sv
// Top level of the stencil derivative ratio block: controller plus datapath.
// Depends on stdr_pkg, stdr_ctrl, stdr_dp (and stdr_div inside the datapath).
//
// Usage:
//   Input channel (i_in_valid / o_in_ready, payload i_in): one sample per beat, with
//   series_start marking the first sample of a new series. Output channel
//   (o_out_valid / i_out_ready, payload o_out): one result per beat. inverse_spacing
//   is written through i_cfg_we / i_cfg_wdata, by the user only while the block is idle.
//   The block does not enforce this. The first four samples of a series give no result.
//   The fifth gives three results (indices 0, 1, 2); every later sample gives one.
//   Each result is formed in steps: stencil accumulate, scaling and a digit-serial
//   divide by three for the derivative, then the radix-2 divider for the ratio, which
//   sets the rate. A zero derivative skips the divider. While a sample is worked on,
//   the block accepts no new sample, so a fifth sample occupies it for all three
//   results and a later one for its single result.
//   Reset (synchronous, active low) empties the window, sets inverse_spacing to
//   256 (1.0 in Q8.8) and drops any pending result.
//   A stalled receiver holds the result in the output register; the next item
//   is still accepted and worked on, and its result waits until the register frees.
module stencil_derivative_ratio_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [stdr_pkg::SPACING_BITS-1:0] i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  stdr_pkg::t_in                     i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output stdr_pkg::t_out                    o_out
);

    // Command and status between controller and datapath
    stdr_pkg::t_dp_cmd  dp_cmd;
    stdr_pkg::t_dp_stat dp_stat;

    // Sequencer: hold each result in flight until the output register frees
    stdr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // Window, arithmetic and the output register
    stdr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out       (o_out),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

endmodule
